@@ src/tdp_pkg.sv @@
package tdp_pkg;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_EVENT = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	// bit of write_value that drives pin 8
	localparam int unsigned PIN_EIGHT_BIT = 2;

	localparam logic       SMOOTH_RESET = 1'b1;
	// active-low buttons, B in bit 1, A in bit 0 (status bits 5 and 4)
	localparam logic [1:0] BTN_RESET    = 2'b11;

	localparam logic signed [8:0] SAT_LOW  = -9'sd8;
	localparam logic signed [8:0] SAT_HIGH = 9'sd7;

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        write_value;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic [1:0]        press_bits;
		logic [1:0]        release_bits;
	} item_t;

	typedef struct packed {
		logic signed [3:0] target_x;
		logic signed [3:0] target_y;
		logic signed [3:0] shown_x;
		logic signed [3:0] shown_y;
		logic              pin_eight;
		logic [1:0]        btn_n;
	} state_t;

	function automatic logic signed [8:0] ext4(input logic signed [3:0] v);
		return {{5{v[3]}}, v};
	endfunction

	function automatic logic signed [8:0] ext8(input logic signed [7:0] v);
		return {v[7], v};
	endfunction

	// clamp to -8..7
	function automatic logic signed [3:0] sat4(input logic signed [8:0] v);
		logic signed [3:0] r;
		if (v < SAT_LOW) begin
			r = SAT_LOW[3:0];
		end else if (v > SAT_HIGH) begin
			r = SAT_HIGH[3:0];
		end else begin
			r = v[3:0];
		end
		return r;
	endfunction

	function automatic logic signed [3:0] step_toward(input logic signed [3:0] cur,
	                                                  input logic signed [3:0] tgt);
		logic signed [3:0] r;
		if (cur < tgt) begin
			r = cur + 4'sd1;
		end else if (cur > tgt) begin
			r = cur - 4'sd1;
		end else begin
			r = cur;
		end
		return r;
	endfunction

endpackage

@@ src/tdp_ifs.sv @@
interface tdp_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [7:0]        write_value;
	logic signed [7:0] move_x;
	logic signed [7:0] move_y;
	logic [1:0]        press_bits;
	logic [1:0]        release_bits;

	modport source (
		output valid, action, write_value, move_x, move_y, press_bits, release_bits,
		input  ready
	);
	modport sink (
		input  valid, action, write_value, move_x, move_y, press_bits, release_bits,
		output ready
	);
endinterface

interface tdp_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

@@ src/tdp_step.sv @@
module tdp_step (
	input  tdp_pkg::state_t cur,
	input  logic            smooth,
	input  tdp_pkg::item_t  item,
	output tdp_pkg::state_t nxt,
	output logic [7:0]      read_data
);

	tdp_pkg::state_t   fol;
	logic signed [3:0] sel;
	logic              newpin;

	always_comb begin
		// follow targets first when smoothing is off (all but events)
		fol = cur;
		if (!smooth && item.action != tdp_pkg::ACT_EVENT) begin
			fol.shown_x = cur.target_x;
			fol.shown_y = cur.target_y;
		end

		sel       = fol.pin_eight ? fol.shown_y : fol.shown_x;
		// offset by 8 in 4 bits: flip the sign bit
		read_data = {2'b00, fol.btn_n, ~sel[3], sel[2:0]};
		newpin    = item.write_value[tdp_pkg::PIN_EIGHT_BIT];

		nxt = fol;
		unique case (item.action)
			tdp_pkg::ACT_READ: begin
			end
			tdp_pkg::ACT_WRITE: begin
				if (newpin != fol.pin_eight) begin
					if (newpin) begin
						nxt.target_x = tdp_pkg::sat4(tdp_pkg::ext4(fol.target_x)
						                             - tdp_pkg::ext4(fol.shown_x));
						nxt.shown_x  = 4'sd0;
					end else begin
						nxt.target_y = tdp_pkg::sat4(tdp_pkg::ext4(fol.target_y)
						                             - tdp_pkg::ext4(fol.shown_y));
						nxt.shown_y  = 4'sd0;
					end
				end
				nxt.pin_eight = newpin;
			end
			tdp_pkg::ACT_EVENT: begin
				nxt.target_x = tdp_pkg::sat4(tdp_pkg::ext4(fol.target_x)
				                             + tdp_pkg::ext8(item.move_x));
				nxt.target_y = tdp_pkg::sat4(tdp_pkg::ext4(fol.target_y)
				                             + tdp_pkg::ext8(item.move_y));
				// release wins over press
				nxt.btn_n = (fol.btn_n & ~item.press_bits) | item.release_bits;
			end
			tdp_pkg::ACT_TICK: begin
				if (smooth) begin
					nxt.shown_x = tdp_pkg::step_toward(fol.shown_x, fol.target_x);
					nxt.shown_y = tdp_pkg::step_toward(fol.shown_y, fol.target_y);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/trackball_delta_port_top.sv @@
// Channel   Role    Payload                                          Carries
// items     sink    action, write_value, move_x, move_y,             one port access,
//                   press_bits, release_bits                         event or tick
// results   source  read_data                                        one per port read
// cfg       write   cfg_we, cfg_wdata                                smooth_enable
//
// One item per cycle sustained while no read is held by a stalled result. An item transfers into
// the input stage and is applied to the state from that stage, where a read also loads its result
// into the output register, which offers the result.
// arst_n clears the state to zero targets and shown values, pin 8 low, both buttons
// released, smoothing on.
// A stalled result holds a following read in the input stage, and the input behind it;
// writes, events and ticks still drain.
module trackball_delta_port_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	tdp_item_if.sink            items,
	tdp_result_if.source        results
);

	tdp_pkg::item_t  item_s1;
	logic            valid_s1;
	tdp_pkg::state_t st_q;
	tdp_pkg::state_t st_next;
	logic            smooth_q;
	logic            res_valid_q;
	logic [7:0]      res_data_q;
	logic [7:0]      rd_next;
	logic            is_read_s1;
	logic            adv_s1;

	assign is_read_s1 = (item_s1.action == tdp_pkg::ACT_READ);
	// advance the held item unless it is a read facing a full, stalled output
	assign adv_s1     = valid_s1 && (!is_read_s1 || !res_valid_q || results.ready);
	assign items.ready = !valid_s1 || adv_s1;

	// configuration register: the user writes it only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= tdp_pkg::SMOOTH_RESET;
		end else if (cfg_we) begin
			smooth_q <= cfg_wdata;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.action       <= items.action;
			item_s1.write_value  <= items.write_value;
			item_s1.move_x       <= items.move_x;
			item_s1.move_y       <= items.move_y;
			item_s1.press_bits   <= items.press_bits;
			item_s1.release_bits <= items.release_bits;
		end
	end

	tdp_step u_step (
		.cur       (st_q),
		.smooth    (smooth_q),
		.item      (item_s1),
		.nxt       (st_next),
		.read_data (rd_next)
	);

	// trackball state: advance once per applied item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.target_x  <= 4'sd0;
			st_q.target_y  <= 4'sd0;
			st_q.shown_x   <= 4'sd0;
			st_q.shown_y   <= 4'sd0;
			st_q.pin_eight <= 1'b0;
			st_q.btn_n     <= tdp_pkg::BTN_RESET;
		end else if (adv_s1) begin
			st_q <= st_next;
		end
	end

	// output register: drop on transfer, load on an applied read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && is_read_s1) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_read_s1) begin
			res_data_q <= rd_next;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.read_data = res_data_q;

`ifndef NO_ASSERTIONS
	// a new result only follows an applied read
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(adv_s1 && is_read_s1))
		else $error("result without a read");

	// back-pressure only from a read blocked by a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!items.ready |-> (valid_s1 && is_read_s1 && res_valid_q && !results.ready))
		else $error("input stalled without cause");

	// with smoothing off, shown tracks target after any non-event item
	a_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(!smooth_q && adv_s1 && item_s1.action != tdp_pkg::ACT_EVENT) |=>
		(st_q.shown_x == st_q.target_x && st_q.shown_y == st_q.target_y))
		else $error("shown value does not follow target");
`endif

endmodule

@@ tb/trackball_delta_port_top_tb.sv @@
`timescale 1ns / 1ps

module trackball_delta_port_top_tb;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 8;
	// settling pause after the last answered read
	localparam int DRAIN_PAUSE  = 6;
	localparam int HOLD_CYCLES  = 200;
	// longest quiet stretch of a correct run is the hold-off plus a long gap
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 150;
	localparam int NO_GOLD      = -1;
	localparam int MAX_REPORTS  = 10;

	typedef struct {
		bit              is_cfg;
		bit              smooth;
		tdp_pkg::item_t  it;
		bit              has_gold;
		logic [7:0]      gold;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	tdp_item_if   items();
	tdp_result_if results();

	trackball_delta_port_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.results   (results)
	);

	// shadow copy of the trackball state, advanced on every item transfer
	bit                trk_smooth;
	logic signed [3:0] trk_target_x;
	logic signed [3:0] trk_target_y;
	logic signed [3:0] trk_shown_x;
	logic signed [3:0] trk_shown_y;
	bit                trk_pin_eight;
	logic [7:0]        trk_buttons;

	logic [7:0] expected_reads[$];
	plan_row_t  plan[$];

	// side channel that rides along with the item on the bus
	bit         tag_gold;
	logic [7:0] tag_val;

	bit calm;        // no random gaps on either side while set
	int hold_asks;   // bumped to ask the result side for a long hold-off
	int fail_count;
	int reports;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic signed [3:0] clamp_nibble(input int v);
		if (v < -8) begin
			v = -8;
		end else if (v > 7) begin
			v = 7;
		end
		return 4'(v);
	endfunction

	function automatic logic signed [3:0] nudge(input logic signed [3:0] cur,
	                                            input logic signed [3:0] tgt);
		if (cur < tgt) begin
			return cur + 4'sd1;
		end else if (cur > tgt) begin
			return cur - 4'sd1;
		end
		return cur;
	endfunction

	// Apply one item to the shadow state; returns 1 with rd filled for a port read.
	function automatic bit advance_trackball(input tdp_pkg::item_t it,
	                                         output logic [7:0] rd);
		logic signed [3:0] sel;
		bit                new_pin;
		bit                has_read;
		has_read = 1'b0;
		rd = '0;
		// with smoothing off every access except an event snaps shown to target
		if (!trk_smooth && it.action != tdp_pkg::ACT_EVENT) begin
			trk_shown_x = trk_target_x;
			trk_shown_y = trk_target_y;
		end
		case (it.action)
			tdp_pkg::ACT_READ: begin
				sel = trk_pin_eight ? trk_shown_y : trk_shown_x;
				rd = {trk_buttons[7:4], 4'(int'(sel) + 8)};
				has_read = 1'b1;
			end
			tdp_pkg::ACT_WRITE: begin
				new_pin = it.write_value[tdp_pkg::PIN_EIGHT_BIT];
				// a toggle hands the shown amount of the axis being left back to it
				if (new_pin != trk_pin_eight) begin
					if (new_pin) begin
						trk_target_x = clamp_nibble(int'(trk_target_x) - int'(trk_shown_x));
						trk_shown_x = '0;
					end else begin
						trk_target_y = clamp_nibble(int'(trk_target_y) - int'(trk_shown_y));
						trk_shown_y = '0;
					end
				end
				trk_pin_eight = new_pin;
			end
			tdp_pkg::ACT_EVENT: begin
				trk_target_x = clamp_nibble(int'(trk_target_x) + int'($signed(it.move_x)));
				trk_target_y = clamp_nibble(int'(trk_target_y) + int'($signed(it.move_y)));
				// active low; a release in the same event wins over a press
				trk_buttons[4] = it.release_bits[0] ? 1'b1 :
				                 (it.press_bits[0] ? 1'b0 : trk_buttons[4]);
				trk_buttons[5] = it.release_bits[1] ? 1'b1 :
				                 (it.press_bits[1] ? 1'b0 : trk_buttons[5]);
			end
			default: begin
				if (trk_smooth) begin
					trk_shown_x = nudge(trk_shown_x, trk_target_x);
					trk_shown_y = nudge(trk_shown_y, trk_target_y);
				end
			end
		endcase
		return has_read;
	endfunction

	// Mostly short gaps, now and then a long one; none while calm.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic tdp_pkg::item_t random_item();
		tdp_pkg::item_t it;
		int             pick;
		it.write_value  = 8'($urandom);
		it.move_x       = 8'($urandom);
		it.move_y       = 8'($urandom);
		it.press_bits   = 2'($urandom);
		it.release_bits = 2'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			it.action = tdp_pkg::ACT_READ;
		end else if (pick < 45) begin
			it.action = tdp_pkg::ACT_WRITE;
		end else if (pick < 70) begin
			it.action = tdp_pkg::ACT_EVENT;
			// keep most motion small so the counters spend time off the rails
			if ($urandom_range(0, 3) != 0) begin
				it.move_x = 8'(int'($urandom_range(0, 6)) - 3);
				it.move_y = 8'(int'($urandom_range(0, 6)) - 3);
			end
		end else begin
			it.action = tdp_pkg::ACT_TICK;
		end
		return it;
	endfunction

	function automatic void add_row(input logic [1:0] act, input logic [7:0] wv,
	                                input int mx, input int my,
	                                input logic [1:0] pr, input logic [1:0] rl,
	                                input int gold);
		plan_row_t row;
		row.is_cfg          = 1'b0;
		row.smooth          = 1'b0;
		row.it.action       = act;
		row.it.write_value  = wv;
		row.it.move_x       = 8'(mx);
		row.it.move_y       = 8'(my);
		row.it.press_bits   = pr;
		row.it.release_bits = rl;
		row.has_gold        = (gold != NO_GOLD);
		row.gold            = 8'(gold);
		plan.push_back(row);
	endfunction

	function automatic void add_cfg(input bit smooth);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.smooth = smooth;
		plan.push_back(row);
	endfunction

	// Offer one item after a random gap and hold it until it transfers.
	task automatic push_item(input tdp_pkg::item_t it, input bit has_gold,
	                         input logic [7:0] gold);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			items.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		items.valid        = 1'b1;
		items.action       = it.action;
		items.write_value  = it.write_value;
		items.move_x       = it.move_x;
		items.move_y       = it.move_y;
		items.press_bits   = it.press_bits;
		items.release_bits = it.release_bits;
		tag_gold           = has_gold;
		tag_val            = gold;
		do @(posedge clk); while (!items.ready);
	endtask

	// Drop valid, wait for every pending read, then let the pipeline empty.
	task automatic drain();
		@(negedge clk);
		items.valid = 1'b0;
		while (expected_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	task automatic set_smoothing(input bit smooth);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = smooth;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	task automatic report_failure(input string what, input logic [7:0] want,
	                              input logic [7:0] got);
		fail_count++;
		if (reports < MAX_REPORTS) begin
			reports++;
			$display("%t %s: read_data expected %h got %h", $realtime, what, want, got);
		end
	endtask

	// Scoreboard: predict on each item transfer, check each result transfer.
	always @(posedge clk) begin
		tdp_pkg::item_t acc;
		logic [7:0]     rd;
		logic [7:0]     want;
		if (arst_n) begin
			if (cfg_we) begin
				trk_smooth = cfg_wdata;
			end
			if (results.valid && results.ready) begin
				if (expected_reads.size() == 0) begin
					report_failure("unexpected result", 8'hxx, results.read_data);
				end else begin
					want = expected_reads.pop_front();
					if (results.read_data !== want) begin
						report_failure("mismatch", want, results.read_data);
					end
				end
			end
			if (items.valid && items.ready) begin
				acc.action       = items.action;
				acc.write_value  = items.write_value;
				acc.move_x       = items.move_x;
				acc.move_y       = items.move_y;
				acc.press_bits   = items.press_bits;
				acc.release_bits = items.release_bits;
				if (advance_trackball(acc, rd)) begin
					expected_reads.push_back(tag_gold ? tag_val : rd);
				end
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request so the block backs up.
	initial begin
		int stall_left;
		int hold_left;
		int hold_seen;
		results.ready = 1'b0;
		stall_left = 0;
		hold_left  = 0;
		hold_seen  = 0;
		forever begin
			@(negedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				results.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				results.ready = 1'b0;
				stall_left--;
			end else begin
				results.ready = 1'b1;
				if ($urandom_range(0, 3) == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens for too long.
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (items.valid && items.ready) || (results.valid && results.ready)) begin
				idle_run = 0;
			end else begin
				idle_run++;
			end
		end
		$display("trackball_delta_port_top_tb: FAIL");
		$finish;
	end

	initial begin
		bit phase_smooth[6];
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		items.valid        = 1'b0;
		items.action       = tdp_pkg::ACT_READ;
		items.write_value  = '0;
		items.move_x       = '0;
		items.move_y       = '0;
		items.press_bits   = '0;
		items.release_bits = '0;
		tag_gold           = 1'b0;
		tag_val            = '0;
		calm               = 1'b0;
		hold_asks          = 0;
		fail_count         = 0;
		reports            = 0;

		// shadow state matches the block's reset
		trk_smooth    = tdp_pkg::SMOOTH_RESET;
		trk_target_x  = '0;
		trk_target_y  = '0;
		trk_shown_x   = '0;
		trk_shown_y   = '0;
		trk_pin_eight = 1'b0;
		trk_buttons   = 8'h3F;

		// Directed plan. Smoothing is on out of reset.
		// read right after reset, with every unused field set to junk
		add_row(tdp_pkg::ACT_READ,  8'hFF, -128,  127, 2'd3, 2'd3, 8'h38);
		// full-scale motion saturates both targets; press both buttons
		add_row(tdp_pkg::ACT_EVENT, 8'h00,  127, -128, 2'd3, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h08);
		add_row(tdp_pkg::ACT_TICK,  8'hA5,   -1,    1, 2'd3, 2'd3, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h09);
		// raise pin 8: X gives back what was shown, read now shows Y
		add_row(tdp_pkg::ACT_WRITE, 8'h04,    5,   -5, 2'd1, 2'd2, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h07);
		// pin 8 already high: nothing moves
		add_row(tdp_pkg::ACT_WRITE, 8'hFF,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h07);
		// press and release together: release wins; saturate the other way
		add_row(tdp_pkg::ACT_EVENT, 8'h00, -128,  127, 2'd3, 2'd3, NO_GOLD);
		add_row(tdp_pkg::ACT_TICK,  8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h38);
		add_row(tdp_pkg::ACT_WRITE, 8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h37);
		add_row(tdp_pkg::ACT_EVENT, 8'h00,    0,    0, 2'd1, 2'd2, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h27);
		// smoothing off: shown snaps to target on access
		add_cfg(1'b0);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, 8'h20);
		add_row(tdp_pkg::ACT_WRITE, 8'h04,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_EVENT, 8'h00,    0,   -3, 2'd2, 2'd1, NO_GOLD);
		add_row(tdp_pkg::ACT_TICK,  8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);
		// back on: stepping resumes from the next tick, no backlog
		add_cfg(1'b1);
		add_row(tdp_pkg::ACT_EVENT, 8'h00,    0,   -8, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_TICK,  8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);
		add_row(tdp_pkg::ACT_READ,  8'h00,    0,    0, 2'd0, 2'd0, NO_GOLD);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				set_smoothing(plan[i].smooth);
			end else begin
				push_item(plan[i].it, plan[i].has_gold, plan[i].gold);
			end
		end

		// Random phases, each with its own smoothing setting.
		phase_smooth = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
		for (int p = 0; p < 6; p++) begin
			drain();
			set_smoothing(phase_smooth[p]);
			calm = (p == 4);
			if (p == 2) begin
				// hold off the result side while a run of reads keeps coming
				hold_asks++;
				calm = 1'b1;
				repeat (24) begin
					tdp_pkg::item_t rd_item;
					rd_item = random_item();
					rd_item.action = tdp_pkg::ACT_READ;
					push_item(rd_item, 1'b0, 8'h00);
				end
				calm = 1'b0;
			end
			repeat (PHASE_ITEMS) push_item(random_item(), 1'b0, 8'h00);
		end

		drain();
		if (fail_count == 0 && expected_reads.size() == 0) begin
			$display("trackball_delta_port_top_tb: PASS");
		end else begin
			$display("trackball_delta_port_top_tb: FAIL");
		end
		$finish;
	end

endmodule
